// ===== hw/rtl/flrc_pkg.sv =====
// ----------------------------------------------------------------------------
// flrc_pkg
// Types, codes and the crc byte step shared by the flash log record checker.
// ----------------------------------------------------------------------------
package flrc_pkg;

	localparam logic [12:0] HEADER_BYTES = 13'd7;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [7:0] TAG_EMPTY = 8'hFF;
	localparam logic [7:0] TAG_M     = 8'h4D;
	localparam logic [7:0] TAG_B     = 8'h42;
	localparam logic [7:0] TAG_F     = 8'h46;
	localparam logic [7:0] TAG_ONE   = 8'h31;
	localparam logic [7:0] REC_ACTIVE = 8'h7F;

	// result status codes
	localparam logic [1:0] STATUS_RECORD    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY     = 2'd1;
	localparam logic [1:0] STATUS_MALFORMED = 2'd2;

	// record type codes
	localparam logic [1:0] TYPE_M = 2'd0;
	localparam logic [1:0] TYPE_B = 2'd1;
	localparam logic [1:0] TYPE_F = 2'd2;

	// configuration register indexes
	localparam logic [7:0] REG_NAME_CAP       = 8'd0;
	localparam logic [7:0] REG_MAX_SHORT_DATA = 8'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       sector_start;
	} flrc_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  record_type;
		logic [7:0]  record_state;
		logic [7:0]  name_bytes;
		logic [15:0] data_bytes;
		logic [12:0] record_offset;
		logic [12:0] rec_bytes;
		logic        crc_ok;
		logic        live;
	} flrc_out_t;

	// crc-16/ccitt-false, one byte, msb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/flash_log_record_checker_core.sv =====
// ----------------------------------------------------------------------------
// flash_log_record_checker_core
// Walks the record area of a flash sector one byte per word, checks each
// record's header and crc, and reports one result per record or stop point.
// ----------------------------------------------------------------------------
//  channel  | direction | payload        | handshake
//  in       | input     | flrc_in_t      | in_valid / in_ready
//  out      | output    | flrc_out_t     | out_valid / out_ready
//  cfg      | input     | index, data    | cfg_valid / cfg_ready (always ready)
//
//  A byte is registered on acceptance, then parsed and crc-stepped from that
//  register, and its result (if any) lands in the output register; one byte
//  per cycle sustained while the output register is empty or being taken.
//  The input register moves whenever the output register is empty or being
//  taken, so a stalled output backs up one word on each side.
//  Reset leaves the parser stopped until a word with sector_start arrives.
module flash_log_record_checker_core #(
	parameter int SECTOR_BYTES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  flrc_pkg::flrc_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output flrc_pkg::flrc_out_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_index,
	input  logic [7:0]          cfg_data
);
	import flrc_pkg::*;

	localparam logic [12:0] SECTOR_END = 13'(SECTOR_BYTES);

	// configuration
	logic [7:0] name_cap_q;
	logic [7:0] max_short_data_q;

	// input stage
	logic     item_valid_s1;
	flrc_in_t item_s1;

	// parser state
	logic [12:0] record_start_q;
	logic [16:0] byte_in_record_q;
	logic [15:0] crc_q;
	logic [7:0]  first_tag_q;
	logic [1:0]  held_type_q;
	logic [7:0]  held_state_q;
	logic [7:0]  held_name_len_q;
	logic [15:0] held_data_len_q;
	logic [15:0] stored_crc_q;
	logic        stopped_q;

	// output register
	logic      out_valid_q;
	flrc_out_t out_data_q;

	// step logic
	logic        advance;
	logic [7:0]  b;
	logic [12:0] n_record_start;
	logic [16:0] n_byte_in_record;
	logic [15:0] n_crc;
	logic [7:0]  n_first_tag;
	logic [1:0]  n_held_type;
	logic [7:0]  n_held_state;
	logic [7:0]  n_held_name_len;
	logic [15:0] n_held_data_len;
	logic [15:0] n_stored_crc;
	logic        n_stopped;
	logic [16:0] k;
	logic [15:0] crc_base;
	logic [15:0] crc_fed;
	logic [3:0]  hdr;
	logic [16:0] total;
	logic [17:0] end_pos;
	logic        emit;
	flrc_out_t   res;

	assign cfg_ready = 1'b1;
	assign advance   = item_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !item_valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign b        = item_s1.data_byte;
	assign crc_base = item_s1.sector_start ? CRC_INIT : crc_q;
	assign crc_fed  = crc_byte(crc_base, b);
	assign hdr      = (held_type_q == TYPE_M) ? 4'd7 : 4'd8;
	assign total    = 17'(hdr) + 17'(held_name_len_q) + 17'(held_data_len_q);

	always_comb begin
		n_record_start   = record_start_q;
		n_byte_in_record = byte_in_record_q;
		n_crc            = crc_q;
		n_first_tag      = first_tag_q;
		n_held_type      = held_type_q;
		n_held_state     = held_state_q;
		n_held_name_len  = held_name_len_q;
		n_held_data_len  = held_data_len_q;
		n_stored_crc     = stored_crc_q;
		n_stopped        = stopped_q;
		emit             = 1'b0;
		res              = '0;
		k                = byte_in_record_q;
		end_pos          = '0;

		if (item_s1.sector_start) begin
			n_record_start   = HEADER_BYTES;
			n_byte_in_record = '0;
			n_crc            = CRC_INIT;
			n_stopped        = 1'b0;
			k                = '0;
		end

		res.record_offset = n_record_start;
		end_pos = 18'(n_record_start) + 18'(total);

		if (!n_stopped) begin
			n_byte_in_record = k + 17'd1;
			priority if (k == 17'd0) begin
				if (b == TAG_EMPTY) begin
					emit       = 1'b1;
					res.status = STATUS_EMPTY;
				end else begin
					n_first_tag = b;
					n_crc       = crc_fed;
				end
			end else if (k == 17'd1) begin
				if (b != TAG_ONE) begin
					emit       = 1'b1;
					res.status = STATUS_MALFORMED;
				end else if (first_tag_q == TAG_M) begin
					n_held_type = TYPE_M;
					n_crc       = crc_fed;
				end else if (first_tag_q == TAG_B) begin
					n_held_type = TYPE_B;
					n_crc       = crc_fed;
				end else if (first_tag_q == TAG_F) begin
					n_held_type = TYPE_F;
					n_crc       = crc_fed;
				end else begin
					emit       = 1'b1;
					res.status = STATUS_MALFORMED;
				end
			end else if (k == 17'd2) begin
				n_held_state = b;
			end else if (k == 17'd3) begin
				if (b == 8'd0 || b >= name_cap_q) begin
					emit       = 1'b1;
					res.status = STATUS_MALFORMED;
				end else begin
					n_held_name_len = b;
					n_crc           = crc_fed;
				end
			end else if (k == 17'd4) begin
				n_held_data_len = {8'd0, b};
				n_crc           = crc_fed;
				if (held_type_q == TYPE_M && b > max_short_data_q) begin
					emit       = 1'b1;
					res.status = STATUS_MALFORMED;
				end
			end else if (k == 17'd5 && held_type_q != TYPE_M) begin
				n_held_data_len = {b, held_data_len_q[7:0]};
				n_crc           = crc_fed;
			end else if (k == 17'(hdr) - 17'd2) begin
				n_stored_crc = {8'd0, b};
			end else if (k == 17'(hdr) - 17'd1) begin
				n_stored_crc = {b, stored_crc_q[7:0]};
				// record must fit in the sector
				if (end_pos > 18'(SECTOR_BYTES)) begin
					emit       = 1'b1;
					res.status = STATUS_MALFORMED;
				end
			end else begin
				n_crc = crc_fed;
				if (!({1'b0, k} + 18'd1 < {1'b0, total})) begin
					emit             = 1'b1;
					res.status       = STATUS_RECORD;
					res.record_type  = held_type_q;
					res.record_state = held_state_q;
					res.name_bytes   = held_name_len_q;
					res.data_bytes   = held_data_len_q;
					res.rec_bytes    = total[12:0];
					res.crc_ok       = (crc_fed == stored_crc_q);
					res.live         = (crc_fed == stored_crc_q) &&
						(held_state_q == REC_ACTIVE);
					n_record_start   = n_record_start + total[12:0];
					n_byte_in_record = '0;
					n_crc            = CRC_INIT;
					if (n_record_start >= SECTOR_END) begin
						n_stopped = 1'b1;
					end
				end
			end
			if (emit && res.status != STATUS_RECORD) begin
				n_stopped = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_cap_q       <= 8'd16;
			max_short_data_q <= 8'd105;
		end else if (cfg_valid) begin
			if (cfg_index == REG_NAME_CAP) begin
				name_cap_q <= cfg_data;
			end else if (cfg_index == REG_MAX_SHORT_DATA) begin
				max_short_data_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_start_q   <= HEADER_BYTES;
			byte_in_record_q <= '0;
			crc_q            <= CRC_INIT;
			first_tag_q      <= '0;
			held_type_q      <= TYPE_M;
			held_state_q     <= '0;
			held_name_len_q  <= '0;
			held_data_len_q  <= '0;
			stored_crc_q     <= '0;
			stopped_q        <= 1'b1;
		end else if (advance) begin
			record_start_q   <= n_record_start;
			byte_in_record_q <= n_byte_in_record;
			crc_q            <= n_crc;
			first_tag_q      <= n_first_tag;
			held_type_q      <= n_held_type;
			held_state_q     <= n_held_state;
			held_name_len_q  <= n_held_name_len;
			held_data_len_q  <= n_held_data_len;
			stored_crc_q     <= n_stored_crc;
			stopped_q        <= n_stopped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_data_q <= res;
		end
	end

endmodule
